FILE: hw/rtl/beacon_frame_parser_defines.svh
// assertion macros for the beacon frame parser rtl
`ifndef BEACON_FRAME_PARSER_DEFINES_SVH
`define BEACON_FRAME_PARSER_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define BFP_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// property whose consequent must hold in the cycle after the antecedent
`define BFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/bfp_pkg.sv
// types and constants of the beacon frame parser
package bfp_pkg;

  localparam logic [31:0] MagicReset = 32'h534D_4231;

  // result queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // output tdata layout, lowest bit up
  localparam int unsigned OutDataW = 48;

  typedef enum logic [3:0] {
    KIND_MAGIC    = 4'd0,
    KIND_NAME_LEN = 4'd1,
    KIND_NAME     = 4'd2,
    KIND_ID_LEN   = 4'd3,
    KIND_ID       = 4'd4,
    KIND_ADDR_LEN = 4'd5,
    KIND_ADDR     = 4'd6,
    KIND_PORT     = 4'd7,
    KIND_OS       = 4'd8,
    KIND_WAKE     = 4'd9,
    KIND_TRAIL    = 4'd10,
    KIND_DISCARD  = 4'd11
  } field_kind_e;

  typedef enum logic [11:0] {
    PH_MAGIC    = 12'b0000_0000_0001,
    PH_NAME_LEN = 12'b0000_0000_0010,
    PH_NAME     = 12'b0000_0000_0100,
    PH_ID_LEN   = 12'b0000_0000_1000,
    PH_ID       = 12'b0000_0001_0000,
    PH_ADDR_LEN = 12'b0000_0010_0000,
    PH_ADDR     = 12'b0000_0100_0000,
    PH_PORT     = 12'b0000_1000_0000,
    PH_OS       = 12'b0001_0000_0000,
    PH_WAKE     = 12'b0010_0000_0000,
    PH_TRAIL    = 12'b0100_0000_0000,
    PH_DISCARD  = 12'b1000_0000_0000
  } phase_e;

  // one classified byte on its way from front to back
  typedef struct packed {
    field_kind_e kind;
    logic [7:0]  data_byte;
    logic        frame_end;
    logic        frame_ok;
    logic [15:0] port_value;
    logic [7:0]  os_code;
    logic [7:0]  wake_capable;
  } result_t;

  // queue occupancy seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic field_kind_e phase_to_kind(phase_e ph);
    field_kind_e k;
    unique case (ph)
      PH_MAGIC:    k = KIND_MAGIC;
      PH_NAME_LEN: k = KIND_NAME_LEN;
      PH_NAME:     k = KIND_NAME;
      PH_ID_LEN:   k = KIND_ID_LEN;
      PH_ID:       k = KIND_ID;
      PH_ADDR_LEN: k = KIND_ADDR_LEN;
      PH_ADDR:     k = KIND_ADDR;
      PH_PORT:     k = KIND_PORT;
      PH_OS:       k = KIND_OS;
      PH_WAKE:     k = KIND_WAKE;
      PH_TRAIL:    k = KIND_TRAIL;
      default:     k = KIND_DISCARD;
    endcase
    return k;
  endfunction

endpackage

FILE: hw/rtl/bfp_front.sv
// front end: magic check and field classification, one byte per cycle while push_i is high
module bfp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_magic_i,
  input  logic              push_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              last_byte_i,
  output bfp_pkg::result_t  result_o
);
  import bfp_pkg::*;

  logic [31:0] magic_q;
  phase_e      phase_q, phase_d;
  logic [15:0] left_q, left_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [1:0]  mag_idx_q, mag_idx_d;
  logic [15:0] port_q, port_d;
  logic [7:0]  os_q, os_d;
  logic [7:0]  wake_q, wake_d;
  logic [7:0]  want;
  logic [15:0] str_len;
  field_kind_e kind;

  always_comb begin
    case (mag_idx_q)
      2'd0:    want = magic_q[31:24];
      2'd1:    want = magic_q[23:16];
      2'd2:    want = magic_q[15:8];
      default: want = magic_q[7:0];
    endcase
  end

  assign str_len = {len_hi_q, rx_byte_i};

  always_comb begin
    phase_d   = phase_q;
    left_d    = left_q;
    len_hi_d  = len_hi_q;
    mag_idx_d = mag_idx_q;
    port_d    = port_q;
    os_d      = os_q;
    wake_d    = wake_q;
    kind      = phase_to_kind(phase_q);
    unique case (phase_q) inside
      PH_MAGIC: begin
        if (rx_byte_i != want) begin
          phase_d = PH_DISCARD;
        end else if (mag_idx_q == 2'd3) begin
          mag_idx_d = 2'd0;
          left_d    = 16'd0;
          phase_d   = PH_NAME_LEN;
        end else begin
          mag_idx_d = mag_idx_q + 2'd1;
        end
      end
      PH_NAME_LEN, PH_ID_LEN, PH_ADDR_LEN: begin
        if (left_q == 16'd0) begin
          len_hi_d = rx_byte_i;
          left_d   = 16'd1;
        end else if (str_len == 16'd0) begin
          // empty string, go straight to the next field
          left_d = 16'd0;
          if (phase_q == PH_NAME_LEN) begin
            phase_d = PH_ID_LEN;
          end else if (phase_q == PH_ID_LEN) begin
            phase_d = PH_ADDR_LEN;
          end else begin
            phase_d = PH_PORT;
          end
        end else begin
          left_d = str_len;
          if (phase_q == PH_NAME_LEN) begin
            phase_d = PH_NAME;
          end else if (phase_q == PH_ID_LEN) begin
            phase_d = PH_ID;
          end else begin
            phase_d = PH_ADDR;
          end
        end
      end
      PH_NAME, PH_ID, PH_ADDR: begin
        left_d = left_q - 16'd1;
        if (left_q == 16'd1) begin
          if (phase_q == PH_NAME) begin
            phase_d = PH_ID_LEN;
          end else if (phase_q == PH_ID) begin
            phase_d = PH_ADDR_LEN;
          end else begin
            phase_d = PH_PORT;
          end
        end
      end
      PH_PORT: begin
        if (left_q == 16'd0) begin
          port_d = {rx_byte_i, 8'h00};
          left_d = 16'd1;
        end else begin
          port_d  = {port_q[15:8], rx_byte_i};
          left_d  = 16'd0;
          phase_d = PH_OS;
        end
      end
      PH_OS: begin
        os_d    = rx_byte_i;
        phase_d = PH_WAKE;
      end
      PH_WAKE: begin
        wake_d  = rx_byte_i;
        phase_d = PH_TRAIL;
      end
      PH_TRAIL: begin
      end
      default: begin
        kind    = KIND_DISCARD;
        phase_d = PH_DISCARD;
      end
    endcase
  end

  always_comb begin
    result_o.kind         = kind;
    result_o.data_byte    = rx_byte_i;
    result_o.frame_end    = last_byte_i;
    result_o.frame_ok     = last_byte_i && (phase_d == PH_TRAIL);
    result_o.port_value   = port_d;
    result_o.os_code      = os_d;
    result_o.wake_capable = wake_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= MagicReset;
    end else if (cfg_we_i) begin
      magic_q <= cfg_magic_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_MAGIC;
      left_q    <= 16'd0;
      len_hi_q  <= 8'd0;
      mag_idx_q <= 2'd0;
      port_q    <= 16'd0;
      os_q      <= 8'd0;
      wake_q    <= 8'd0;
    end else if (push_i) begin
      if (last_byte_i) begin
        // datagram done, next byte starts a new one
        phase_q   <= PH_MAGIC;
        left_q    <= 16'd0;
        len_hi_q  <= 8'd0;
        mag_idx_q <= 2'd0;
        port_q    <= 16'd0;
        os_q      <= 8'd0;
        wake_q    <= 8'd0;
      end else begin
        phase_q   <= phase_d;
        left_q    <= left_d;
        len_hi_q  <= len_hi_d;
        mag_idx_q <= mag_idx_d;
        port_q    <= port_d;
        os_q      <= os_d;
        wake_q    <= wake_d;
      end
    end
  end

endmodule

FILE: hw/rtl/bfp_queue.sv
// short result queue decoupling the front end from the output stage
`include "beacon_frame_parser_defines.svh"

module bfp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bfp_pkg::result_t    push_data_i,
  input  logic                pop_i,
  output bfp_pkg::result_t    pop_data_o,
  output bfp_pkg::q_status_t  status_o
);
  import bfp_pkg::*;

  result_t            mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]   cnt_q;

  assign status_o.full  = (cnt_q == QCntW'(QDepth));
  assign status_o.empty = (cnt_q == '0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `BFP_ASSERT_ALWAYS(a_no_overflow, !(push_i && status_o.full), "push into full queue")
  `BFP_ASSERT_ALWAYS(a_no_underflow, !(pop_i && status_o.empty), "pop from empty queue")
  `BFP_ASSERT_NEXT(a_cnt_track, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1, "count lost a push")
  `BFP_ASSERT_NEXT(a_ptr_gap, 1'b1, status_o.empty || (cnt_q != '0), "count and empty disagree")

endmodule

FILE: hw/rtl/bfp_back.sv
// output stage: result formatting and master-side register
module bfp_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bfp_pkg::q_status_t            q_status_i,
  input  bfp_pkg::result_t              q_data_i,
  output logic                          pop_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [bfp_pkg::OutDataW-1:0]  m_axis_tdata_o,
  output logic [3:0]                    m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);
  import bfp_pkg::*;

  logic                valid_q;
  logic [OutDataW-1:0] data_q;
  logic [3:0]          user_q;
  logic                last_q;
  logic [OutDataW-1:0] data_d;
  logic                ok;

  assign pop_o = !q_status_i.empty && (!valid_q || m_axis_tready_i);
  assign ok    = q_data_i.frame_ok;

  // decoded values only show on a good frame end
  always_comb begin
    data_d        = '0;
    data_d[7:0]   = q_data_i.data_byte;
    data_d[8]     = ok;
    data_d[24:9]  = ok ? q_data_i.port_value : 16'd0;
    data_d[32:25] = ok ? q_data_i.os_code : 8'd0;
    data_d[40:33] = ok ? q_data_i.wake_capable : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= data_d;
      user_q <= q_data_i.kind;
      last_q <= q_data_i.frame_end;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tuser_o  = user_q;
  assign m_axis_tlast_o  = last_q;

endmodule

FILE: hw/rtl/beacon_frame_parser.sv
// top level of the beacon frame parser
// Byte-serial parser for a discovery datagram: four magic bytes, three strings
// (name, id, address) each led by a 16-bit big-endian length, a 16-bit port,
// an os byte and a wake byte. Every input transaction yields exactly one output
// transaction that tags the byte with its field kind and passes it through;
// on the byte marked tlast the output reports whether the magic matched and
// the datagram was complete through the wake byte, with the decoded port, os
// and wake values (zero otherwise). The front end classifies a byte in the
// cycle it is accepted, so one byte per clock is sustained while the master
// side keeps up; a two-entry queue and an output register sit between it and
// the master side, and m_axis_tvalid is driven by that output register.
// s_axis_tready only drops while the queue is full, i.e. while the master
// side stalls. The user must write the magic word through the cfg channel
// (always ready) only while the block is idle; the block does not enforce it.
module beacon_frame_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // magic word, first byte in bits 31:24
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [31:0]                   cfg_data_i,
  // tdata: rx_byte[7:0]
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,
  input  logic                          s_axis_tlast_i,
  // tdata: data_byte[7:0], frame_ok[8], port_value[24:9], os_code[32:25],
  //        wake_capable[40:33], zero[47:41]
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [bfp_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // tuser: field_kind[3:0]
  output logic [3:0]                    m_axis_tuser_o,
  // tlast: frame_end
  output logic                          m_axis_tlast_o
);
  import bfp_pkg::*;

  logic      push;
  logic      pop;
  result_t   front_res;
  result_t   q_head;
  q_status_t q_status;

  // config writes are taken at any time
  assign cfg_ready_o = 1'b1;

  // a byte is accepted whenever the queue has room
  assign s_axis_tready_o = !q_status.full;
  assign push            = s_axis_tvalid_i && s_axis_tready_o;

  // front end: parse state and classification
  bfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_magic_i (cfg_data_i),
    .push_i      (push),
    .rx_byte_i   (s_axis_tdata_i),
    .last_byte_i (s_axis_tlast_i),
    .result_o    (front_res)
  );

  // decoupling queue
  bfp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_res),
    .pop_i       (pop),
    .pop_data_o  (q_head),
    .status_o    (q_status)
  );

  // back end: format and present the result
  bfp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_status_i      (q_status),
    .q_data_i        (q_head),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
